@@ sv/azc_pkg.sv @@
package azc_pkg;

   // Widths of the transaction fields: time width fixed, value width a default
   localparam int TIME_W = 63;
   localparam int VALUE_WIDTH_DEF = 32;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_MODE = '0;
   localparam logic LINEAR_MODE_RESET = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic mul_step;
      logic div_init;
      logic div_step;
      logic load_cross;
      logic load_sample;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cross_needed;
      logic keep_cross;
      logic out_free;
   } sts_type;

endpackage

@@ sv/azc_csr.sv @@
module azc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [azc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [azc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [azc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic                               linear_mode
);

   logic                              linear_mode_ff;
   logic                              linear_mode_in;
   logic [azc_pkg::CSR_IDX_W-1:0]     reg_idx;
   logic                              wr_en;

   assign reg_idx = paddr[azc_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      linear_mode_in = linear_mode_ff;
      if (wr_en && (reg_idx == azc_pkg::REG_LINEAR_MODE)) begin
         linear_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_mode_ff <= azc_pkg::LINEAR_MODE_RESET;
      end else begin
         linear_mode_ff <= linear_mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == azc_pkg::REG_LINEAR_MODE) begin
         prdata[0] = linear_mode_ff;
      end
   end

   assign linear_mode = linear_mode_ff;

endmodule

@@ sv/azc_ctrl.sv @@
module azc_ctrl #(
   parameter int VALUE_WIDTH = azc_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  azc_pkg::sts_type  sts,
   output azc_pkg::cmd_type  cmd
);

   localparam int MAX_STEPS = (VALUE_WIDTH > azc_pkg::TIME_W) ? VALUE_WIDTH : azc_pkg::TIME_W;
   localparam int CNT_W = $clog2(MAX_STEPS);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(azc_pkg::TIME_W - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MUL    = 6'b000010,
      S_DINIT  = 6'b000100,
      S_DIV    = 6'b001000,
      S_CROSS  = 6'b010000,
      S_SAMPLE = 6'b100000
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.cross_needed ? S_MUL : S_SAMPLE;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_CROSS;
            end
         end
         S_CROSS: begin
            // drop a crossing that lands on either end
            if (!sts.keep_cross) begin
               state_in = S_SAMPLE;
            end else if (sts.out_free) begin
               cmd.load_cross = 1'b1;
               state_in       = S_SAMPLE;
            end
         end
         S_SAMPLE: begin
            if (sts.out_free) begin
               cmd.load_sample = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ sv/azc_dp.sv @@
module azc_dp #(
   parameter int VALUE_WIDTH = azc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  azc_pkg::cmd_type              cmd,
   output azc_pkg::sts_type              sts,
   input  logic                          linear_mode,
   input  logic [VALUE_WIDTH-1:0]        req_sample_value,
   input  logic [azc_pkg::TIME_W-1:0]    req_sample_time,
   input  logic                          req_first_of_sequence,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [VALUE_WIDTH-2:0]        rsp_out_value,
   output logic [azc_pkg::TIME_W-1:0]    rsp_out_time,
   output logic                          rsp_is_crossing,
   output logic                          rsp_last_of_run
);

   localparam int TW     = azc_pkg::TIME_W;
   localparam int MAG_W  = VALUE_WIDTH;
   localparam int SUM_W  = VALUE_WIDTH + 1;
   localparam int PROD_W = TW + MAG_W;

   // previous sample of the sequence
   logic [VALUE_WIDTH-1:0] prev_value_ff, prev_value_in;
   logic [TW-1:0]          prev_time_ff, prev_time_in;
   logic                   have_prev_ff, have_prev_in;

   // working registers of the current transaction
   logic [TW-1:0]          t1_ff, t1_in;
   logic [TW-1:0]          t2_ff, t2_in;
   logic                   back_ff, back_in;
   logic [TW-1:0]          d_ff, d_in;
   logic [MAG_W-1:0]       a_ff, a_in;
   logic [SUM_W-1:0]       s_ff, s_in;
   logic [VALUE_WIDTH-2:0] sat_ff, sat_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [SUM_W-1:0]       rem_ff, rem_in;
   logic [TW-1:0]          dq_ff, dq_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-2:0] out_value_ff, out_value_in;
   logic [TW-1:0]          out_time_ff, out_time_in;
   logic                   is_crossing_ff, is_crossing_in;
   logic                   last_of_run_ff, last_of_run_in;

   logic [MAG_W-1:0]       mag_prev;
   logic [MAG_W-1:0]       mag_new;
   logic                   prev_nz;
   logic                   new_nz;
   logic                   new_back;
   logic [SUM_W:0]         rem_shift;
   logic [SUM_W:0]         rem_diff;
   logic                   rem_ge;
   logic [TW-1:0]          t_cross;

   assign mag_prev = prev_value_ff[VALUE_WIDTH-1] ? (~prev_value_ff + 1'b1) : prev_value_ff;
   assign mag_new  = req_sample_value[VALUE_WIDTH-1] ?
                     (~req_sample_value + 1'b1) : req_sample_value;
   assign prev_nz  = |prev_value_ff;
   assign new_nz   = |req_sample_value;
   assign new_back = req_sample_time < prev_time_ff;

   assign sts.cross_needed = linear_mode & have_prev_ff & ~req_first_of_sequence &
                             prev_nz & new_nz &
                             (prev_value_ff[VALUE_WIDTH-1] ^ req_sample_value[VALUE_WIDTH-1]);

   // restoring division step
   assign rem_shift = {rem_ff, dq_ff[TW-1]};
   assign rem_diff  = rem_shift - {1'b0, s_ff};
   assign rem_ge    = rem_shift >= {1'b0, s_ff};

   assign t_cross        = back_ff ? (t1_ff - dq_ff) : (t1_ff + dq_ff);
   assign sts.keep_cross = (t_cross != t1_ff) && (t_cross != t2_ff);
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      prev_value_in  = prev_value_ff;
      prev_time_in   = prev_time_ff;
      have_prev_in   = have_prev_ff;
      t1_in          = t1_ff;
      t2_in          = t2_ff;
      back_in        = back_ff;
      d_in           = d_ff;
      a_in           = a_ff;
      s_in           = s_ff;
      sat_in         = sat_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      dq_in          = dq_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      out_value_in   = out_value_ff;
      out_time_in    = out_time_ff;
      is_crossing_in = is_crossing_ff;
      last_of_run_in = last_of_run_ff;

      if (cmd.capture) begin
         t1_in         = prev_time_ff;
         t2_in         = req_sample_time;
         back_in       = new_back;
         d_in          = new_back ? (prev_time_ff - req_sample_time) :
                                    (req_sample_time - prev_time_ff);
         a_in          = mag_prev;
         s_in          = {1'b0, mag_prev} + {1'b0, mag_new};
         sat_in        = mag_new[MAG_W-1] ? '1 : mag_new[MAG_W-2:0];
         acc_in        = '0;
         prev_value_in = req_sample_value;
         prev_time_in  = req_sample_time;
         have_prev_in  = 1'b1;
      end

      // shift-add multiply, most significant bit of the magnitude first
      if (cmd.mul_step) begin
         acc_in = (acc_ff << 1) + (a_ff[MAG_W-1] ? PROD_W'(d_ff) : '0);
         a_in   = a_ff << 1;
      end

      // upper product bits stay below the divisor since the quotient fits the time width
      if (cmd.div_init) begin
         rem_in = SUM_W'(acc_ff[PROD_W-1:TW]);
         dq_in  = acc_ff[TW-1:0];
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
         dq_in  = {dq_ff[TW-2:0], rem_ge};
      end

      if (cmd.load_cross) begin
         rsp_valid_in   = 1'b1;
         out_value_in   = '0;
         out_time_in    = t_cross;
         is_crossing_in = 1'b1;
         last_of_run_in = 1'b0;
      end

      if (cmd.load_sample) begin
         rsp_valid_in   = 1'b1;
         out_value_in   = sat_ff;
         out_time_in    = t2_ff;
         is_crossing_in = 1'b0;
         last_of_run_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_value_ff  <= prev_value_in;
      prev_time_ff   <= prev_time_in;
      t1_ff          <= t1_in;
      t2_ff          <= t2_in;
      back_ff        <= back_in;
      d_ff           <= d_in;
      a_ff           <= a_in;
      s_ff           <= s_in;
      sat_ff         <= sat_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      dq_ff          <= dq_in;
      out_value_ff   <= out_value_in;
      out_time_ff    <= out_time_in;
      is_crossing_ff <= is_crossing_in;
      last_of_run_ff <= last_of_run_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_time    = out_time_ff;
   assign rsp_is_crossing = is_crossing_ff;
   assign rsp_last_of_run = last_of_run_ff;

endmodule

@@ sv/abs_with_zero_crossing_insert_core.sv @@
// Plain sample: after acceptance the sample state loads the result into the output register
// once it is free, then returns to idle. Sign change in linear mode: a serial shift-add
// multiply, a divider load, a serial restoring divide over the time width, then the crossing
// result (unless it lands on either end) and the sample result are loaded in turn.
// A waiting result sits in the output register while the next transaction is accepted.
// Synchronous active-high reset: no previous sample, linear mode on, output empty.
module abs_with_zero_crossing_insert_core #(
   parameter int VALUE_WIDTH = azc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [VALUE_WIDTH-1:0]            req_sample_value,
   input  logic [azc_pkg::TIME_W-1:0]        req_sample_time,
   input  logic                              req_first_of_sequence,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [VALUE_WIDTH-2:0]            rsp_out_value,
   output logic [azc_pkg::TIME_W-1:0]        rsp_out_time,
   output logic                              rsp_is_crossing,
   output logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [azc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [azc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [azc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   azc_pkg::cmd_type cmd;
   azc_pkg::sts_type sts;
   logic             linear_mode;

   azc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .linear_mode (linear_mode)
   );

   azc_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   azc_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .linear_mode           (linear_mode),
      .req_sample_value      (req_sample_value),
      .req_sample_time       (req_sample_time),
      .req_first_of_sequence (req_first_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_value         (rsp_out_value),
      .rsp_out_time          (rsp_out_time),
      .rsp_is_crossing       (rsp_is_crossing),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

@@ sv/azc_checker.sv @@
module azc_checker #(
   parameter int VALUE_WIDTH = azc_pkg::VALUE_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [VALUE_WIDTH-2:0]        rsp_out_value,
   input logic [azc_pkg::TIME_W-1:0]    rsp_out_time,
   input logic                          rsp_is_crossing,
   input logic                          rsp_last_of_run
);

   // output register comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value) &&
      $stable(rsp_out_time) && $stable(rsp_is_crossing) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // a crossing is zero and never ends a run; a sample always ends it
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_crossing != rsp_last_of_run) &&
      (!rsp_is_crossing || rsp_out_value == '0))
      else $error("malformed result kind");

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted back to back");

endmodule

bind abs_with_zero_crossing_insert_core azc_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_azc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_value   (rsp_out_value),
   .rsp_out_time    (rsp_out_time),
   .rsp_is_crossing (rsp_is_crossing),
   .rsp_last_of_run (rsp_last_of_run)
);

@@ test/tb_abs_with_zero_crossing_insert_core.sv @@
module tb_abs_with_zero_crossing_insert_core;

   localparam int VW = azc_pkg::VALUE_WIDTH_DEF;
   localparam int TIME_W = azc_pkg::TIME_W;
   localparam int CSR_ADDR_W = azc_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = azc_pkg::CSR_DATA_W;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 120;
   localparam logic [CSR_ADDR_W-1:0] LINEAR_MODE_ADDR = {azc_pkg::REG_LINEAR_MODE, 2'b00};

   typedef struct {
      logic [VW-2:0]     value;
      logic [TIME_W-1:0] stamp;
      logic              crossing;
      logic              last;
   } abs_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VW-1:0]         req_sample_value = '0;
   logic [TIME_W-1:0]     req_sample_time = '0;
   logic                  req_first_of_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VW-2:0]         rsp_out_value;
   logic [TIME_W-1:0]     rsp_out_time;
   logic                  rsp_is_crossing;
   logic                  rsp_last_of_run;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state
   logic              mode_linear = azc_pkg::LINEAR_MODE_RESET;
   logic [VW-1:0]     seen_value = '0;
   logic [TIME_W-1:0] seen_stamp = '0;
   logic              seen_valid = 1'b0;
   abs_result_type    pending_abs_out[$];

   int          error_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_off = 0;
   int unsigned cycle_count = 0;

   abs_with_zero_crossing_insert_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_value(req_sample_value),
      .req_sample_time(req_sample_time),
      .req_first_of_sequence(req_first_of_sequence),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_value(rsp_out_value),
      .rsp_out_time(rsp_out_time),
      .rsp_is_crossing(rsp_is_crossing),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [VW:0] magnitude_of(logic [VW-1:0] v);
      return v[VW-1] ? {1'b0, (~v) + 1'b1} : {1'b0, v};
   endfunction

   function automatic void predict_abs_and_crossing(logic [VW-1:0] v2, logic [TIME_W-1:0] t2,
                                                    logic first);
      logic [VW:0]       a;
      logic [VW:0]       b;
      logic [VW:0]       mag;
      logic [VW+1:0]     den;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] cross_t;
      logic [127:0]      prod;
      logic [127:0]      quot;
      abs_result_type    r;
      if (mode_linear && seen_valid && !first && v2 != '0 && seen_value != '0 &&
          v2[VW-1] != seen_value[VW-1]) begin
         a = magnitude_of(seen_value);
         b = magnitude_of(v2);
         den = a + b;
         span = (t2 >= seen_stamp) ? t2 - seen_stamp : seen_stamp - t2;
         prod = {65'd0, span} * {{(128-VW-1){1'b0}}, a};
         quot = prod / {{(128-VW-2){1'b0}}, den};
         // truncate toward the earlier sample in either direction
         cross_t = (t2 >= seen_stamp) ? seen_stamp + quot[TIME_W-1:0]
                                      : seen_stamp - quot[TIME_W-1:0];
         if (cross_t != seen_stamp && cross_t != t2) begin
            r.value = '0;
            r.stamp = cross_t;
            r.crossing = 1'b1;
            r.last = 1'b0;
            pending_abs_out.push_back(r);
         end
      end
      mag = magnitude_of(v2);
      r.value = (mag > {2'b00, {(VW-1){1'b1}}}) ? {(VW-1){1'b1}} : mag[VW-2:0];
      r.stamp = t2;
      r.crossing = 1'b0;
      r.last = 1'b1;
      pending_abs_out.push_back(r);
      seen_value = v2;
      seen_stamp = t2;
      seen_valid = 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      abs_result_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr == LINEAR_MODE_ADDR)
            mode_linear = pwdata[0];
         if (req_valid && req_ready)
            predict_abs_and_crossing(req_sample_value, req_sample_time, req_first_of_sequence);
         if (rsp_valid && rsp_ready) begin
            if (pending_abs_out.size() == 0) begin
               $error("unexpected result: out_value %0d out_time %0d is_crossing %0d",
                      rsp_out_value, rsp_out_time, rsp_is_crossing);
               error_count++;
            end else begin
               want = pending_abs_out.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, actual %0d", want.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_out_time !== want.stamp) begin
                  $error("out_time: expected %0d, actual %0d", want.stamp, rsp_out_time);
                  error_count++;
               end
               if (rsp_is_crossing !== want.crossing) begin
                  $error("is_crossing: expected %0d, actual %0d", want.crossing,
                         rsp_is_crossing);
                  error_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver: long hold-off first, then random stalls
   always @(negedge clock) begin
      if (rsp_hold_off > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_off--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_sample(logic [VW-1:0] value, logic [TIME_W-1:0] stamp, logic first);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_sample_value = value;
      req_sample_time = stamp;
      req_first_of_sequence = first;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_abs_out.size() != 0) @(negedge clock);
   endtask

   task automatic csr_check_linear_mode(logic want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = LINEAR_MODE_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (got !== {{(CSR_DATA_W-1){1'b0}}, want}) begin
         $error("linear_mode: expected %0d, actual %0d", want, got);
         error_count++;
      end
   endtask

   task automatic csr_write_linear_mode(logic mode);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = LINEAR_MODE_ADDR;
      pwdata = {{(CSR_DATA_W-1){1'b0}}, mode};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      csr_check_linear_mode(mode);
   endtask

   function automatic logic [VW-1:0] pick_value(logic negative);
      logic [VW-1:0] mag;
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return {1'b1, {(VW-1){1'b0}}};
         2: return {1'b0, {(VW-1){1'b1}}};
         3: return '0;
         default: begin
            mag = $urandom >> $urandom_range(0, 31);
            mag[VW-1] = 1'b0;
            if (mag == '0) mag = 1;
            return negative ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] next_stamp(logic [TIME_W-1:0] prev);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return prev;
         1: return prev + $urandom_range(1, 3);
         2, 3: return prev + ($urandom >> $urandom_range(8, 31));
         4: return prev - ($urandom >> $urandom_range(12, 31));
         5: return r[TIME_W-1:0];
         default: return prev + $urandom_range(1, 100000);
      endcase
   endfunction

   task automatic test_reset_value();
      csr_check_linear_mode(azc_pkg::LINEAR_MODE_RESET);
   endtask

   task automatic test_directed_cases();
      // no previous sample yet although first_of_sequence is low
      send_sample(-32'd5, 63'd1000, 1'b0);
      send_sample(32'd7, 63'd1012, 1'b0);
      // new sequence: no crossing despite sign change
      send_sample(32'h8000_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      // time going backwards over the full range
      send_sample(32'h7FFF_FFFF, 63'd0, 1'b0);
      send_sample(32'd0, 63'd50, 1'b0);
      send_sample(-32'd3, 63'd60, 1'b0);
      // equal times: crossing dropped
      send_sample(32'd3, 63'd60, 1'b0);
      // crossing collapses onto an end point and is dropped
      send_sample(-32'd1000, 63'd61, 1'b0);
      send_sample(32'd1, 63'd63, 1'b0);
      send_sample(-32'd2147483647, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 63'd5, 1'b0);
      send_sample(32'h7FFF_FFFF, 63'h4000_0000_0000_0000, 1'b0);
      send_sample(-32'd1, 63'h4000_0000_0000_0001, 1'b0);
      send_sample(32'd1, 63'h7FFF_FFFF_FFFF_FFFE, 1'b0);
      wait_for_results_drained();
   endtask

   task automatic test_mode_switch();
      csr_write_linear_mode(1'b0);
      send_sample(-32'd9, 63'd100, 1'b1);
      send_sample(32'd9, 63'd200, 1'b0);
      send_sample(-32'd9, 63'd300, 1'b0);
      wait_for_results_drained();
      // pair spanning the switch uses the new mode
      csr_write_linear_mode(1'b1);
      send_sample(32'd9, 63'd400, 1'b0);
      send_sample(-32'd9, 63'd500, 1'b0);
      wait_for_results_drained();
   endtask

   task automatic test_backpressure();
      logic [TIME_W-1:0] stamp;
      logic [VW-1:0]     mag;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      rsp_hold_off = 300;
      stamp = 63'd5000;
      for (int k = 0; k < 24; k++) begin
         mag = 100 + k;
         send_sample((k % 2 == 1) ? mag : -mag, stamp, k == 0);
         stamp = stamp + 997;
      end
      wait_for_results_drained();
   endtask

   task automatic drive_random_samples(int count);
      int                sent;
      int                run_len;
      logic [63:0]       r;
      logic [TIME_W-1:0] stamp;
      logic              was_neg;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: anything in any field
            r = {$urandom, $urandom};
            send_sample($urandom, r[TIME_W-1:0], 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            run_len = $urandom_range(1, 12);
            r = {$urandom, $urandom};
            stamp = r[TIME_W-1:0] >> $urandom_range(1, 24);
            was_neg = 1'($urandom_range(0, 1));
            for (int k = 0; k < run_len && sent < count; k++) begin
               if ($urandom_range(0, 9) < 7) was_neg = !was_neg;
               if (k > 0) stamp = next_stamp(stamp);
               send_sample(pick_value(was_neg), stamp,
                           (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      int idle_tab [4] = '{0, 51, 0, 28};
      int stall_tab [4] = '{0, 0, 51, 28};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_tab[phase];
         rsp_stall_pct = stall_tab[phase];
         for (int seg = 0; seg < 3; seg++) begin
            wait_for_results_drained();
            csr_write_linear_mode($urandom_range(0, 3) != 0);
            drive_random_samples(150);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_value();
      test_directed_cases();
      test_mode_switch();
      test_backpressure();
      test_random_traffic();
      wait_for_results_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
